// ===== src/sbpd_pkg.sv =====
// shared types, constants and helpers for the sign-bit packet deframer
package sbpd_pkg;

    localparam int ByteW   = 8;
    localparam int SignW   = 7;
    localparam int NumData = 4;
    localparam int SyncBit = 7;

    // sign byte bit that carries each field's top bit
    localparam int SignHdr  = 6;
    localparam int SignAddr = 5;
    localparam int SignData0 = 4;
    localparam int SignChk  = 0;

    typedef logic [2:0] t_pos;

    localparam t_pos POS_HUNT = 3'd0;
    localparam t_pos POS_SIGN = 3'd1;
    localparam t_pos POS_ADDR = 3'd2;
    localparam t_pos POS_D0   = 3'd3;
    localparam t_pos POS_D3   = 3'd6;
    localparam t_pos POS_CHK  = 3'd7;

    typedef struct packed {
        logic [ByteW-1:0]              header;
        logic [SignW-1:0]              sign;
        logic [ByteW-1:0]              addr;
        logic [NumData-1:0][ByteW-1:0] data;
        logic [ByteW-1:0]              chk;
    } t_pkt;

    typedef struct packed {
        logic [ByteW-1:0]              header;
        logic [ByteW-1:0]              addr;
        logic [NumData-1:0][ByteW-1:0] data;
    } t_res;

    function automatic logic [ByteW-1:0] restore_top(input logic [ByteW-1:0] v,
                                                     input logic              top);
        restore_top = {top, v[ByteW-2:0]};
    endfunction

endpackage

// ===== src/sbpd_frame.sv =====
// byte position tracking and packet byte capture
module sbpd_frame (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_byte,
    output logic                 o_pkt_valid,
    output sbpd_pkg::t_pkt       o_pkt
);

    sbpd_pkg::t_pos                r_pos, n_pos;
    logic [7:0]                    r_header;
    logic [sbpd_pkg::SignW-1:0]    r_sign;
    logic [7:0]                    r_addr;
    logic [sbpd_pkg::NumData-1:0][7:0] r_data;
    logic                          is_sync;
    logic [1:0]                    data_idx;

    assign is_sync  = i_byte[sbpd_pkg::SyncBit];
    // positions 3..6 map to data slots 0..3
    assign data_idx = r_pos[1:0] + 2'd1;

    always_comb begin
        n_pos = r_pos;
        if (i_accept) begin
            if (is_sync) begin
                n_pos = sbpd_pkg::POS_SIGN;
            end else begin
                case (r_pos)
                    sbpd_pkg::POS_HUNT: n_pos = sbpd_pkg::POS_HUNT;
                    sbpd_pkg::POS_CHK:  n_pos = sbpd_pkg::POS_HUNT;
                    default:            n_pos = r_pos + 3'd1;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos <= sbpd_pkg::POS_HUNT;
        end else begin
            r_pos <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (is_sync) begin
                r_header <= i_byte;
            end else begin
                case (r_pos) inside
                    sbpd_pkg::POS_SIGN: r_sign <= i_byte[sbpd_pkg::SignW-1:0];
                    sbpd_pkg::POS_ADDR: r_addr <= i_byte;
                    [sbpd_pkg::POS_D0:sbpd_pkg::POS_D3]: r_data[data_idx] <= i_byte;
                    default: ;
                endcase
            end
        end
    end

    assign o_pkt_valid   = i_accept && !is_sync && (r_pos == sbpd_pkg::POS_CHK);
    assign o_pkt.header  = r_header;
    assign o_pkt.sign    = r_sign;
    assign o_pkt.addr    = r_addr;
    assign o_pkt.data    = r_data;
    assign o_pkt.chk     = i_byte;

    a_sync_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && is_sync) |=> (r_pos == sbpd_pkg::POS_SIGN))
        else $error("header beat did not restart the packet");

    a_chk_back_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pkt_valid |=> (r_pos == sbpd_pkg::POS_HUNT))
        else $error("position not back to hunting after checksum beat");

endmodule

// ===== src/sbpd_check.sv =====
// top bit restore, checksum compare and result register
module sbpd_check (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_pkt_valid,
    input  sbpd_pkg::t_pkt     i_pkt,
    output logic               o_pkt_ready,
    input  logic               i_stall,
    output logic               o_valid,
    output sbpd_pkg::t_res     o_res
);

    logic             r_pkt_valid;
    sbpd_pkg::t_pkt   r_pkt;
    logic             r_out_valid;
    sbpd_pkg::t_res   r_out;
    sbpd_pkg::t_res   res;
    logic [7:0]       chk;
    logic [7:0]       sum;
    logic             good;
    logic             out_ready;

    always_comb begin
        res.header = sbpd_pkg::restore_top(r_pkt.header, r_pkt.sign[sbpd_pkg::SignHdr]);
        res.addr   = sbpd_pkg::restore_top(r_pkt.addr, r_pkt.sign[sbpd_pkg::SignAddr]);
        for (int k = 0; k < sbpd_pkg::NumData; k++) begin
            res.data[k] = sbpd_pkg::restore_top(r_pkt.data[k],
                                                r_pkt.sign[sbpd_pkg::SignData0 - k]);
        end
        chk = sbpd_pkg::restore_top(r_pkt.chk, r_pkt.sign[sbpd_pkg::SignChk]);
        sum = res.header + res.addr + res.data[0] + res.data[1] + res.data[2] + res.data[3];
        good = (sum == chk);
    end

    assign out_ready   = !r_out_valid || !i_stall;
    assign o_pkt_ready = !r_pkt_valid || out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pkt_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pkt_ready) begin
                r_pkt_valid <= i_pkt_valid;
            end
            if (out_ready) begin
                // bad packets fall out here
                r_out_valid <= r_pkt_valid && good;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pkt_ready && i_pkt_valid) begin
            r_pkt <= i_pkt;
        end
        if (out_ready && r_pkt_valid) begin
            r_out <= res;
        end
    end

    assign o_valid = r_out_valid;
    assign o_res   = r_out;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pkt_valid |-> o_pkt_ready)
        else $error("packet arrived while check stage was blocked");

    a_out_from_pkt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_pkt_valid))
        else $error("result appeared without a packet behind it");

endmodule

// ===== src/sign_bit_packet_deframer.sv =====
// top level of the sign-bit packet deframer
//
// input channel: one received byte per beat on i_rx_byte, taken when i_valid
// is high and o_stall is low. a byte with bit 7 set is a header and starts a
// packet; header, sign, address, four data bytes and checksum follow in that
// order. bytes without bit 7 are dropped while hunting for a header.
// output channel: one beat per good packet, six bytes with their top bits
// restored from the sign byte, taken when o_valid is high and i_stall is low.
// packets whose checksum does not match are dropped without any output.
// throughput: one byte per cycle while o_stall is low. a finished packet
// passes the packet register, then the result register, before o_valid
// rises with its result beat.
// when the receiver stalls, the result holds; o_stall rises only once both
// the packet register and the result register are full.
// reset returns the block to hunting and empties both registers; a partial
// packet is lost.
module sign_bit_packet_deframer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_header_byte,
    output logic [7:0] o_address_byte,
    output logic [7:0] o_data_byte0,
    output logic [7:0] o_data_byte1,
    output logic [7:0] o_data_byte2,
    output logic [7:0] o_data_byte3
);

    logic             pkt_ready;
    logic             accept;
    logic             pkt_valid;
    sbpd_pkg::t_pkt   pkt;
    sbpd_pkg::t_res   res;

    assign o_stall = !pkt_ready;
    assign accept  = i_valid && pkt_ready;

    sbpd_frame u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (i_rx_byte),
        .o_pkt_valid (pkt_valid),
        .o_pkt       (pkt)
    );

    sbpd_check u_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pkt_valid (pkt_valid),
        .i_pkt       (pkt),
        .o_pkt_ready (pkt_ready),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_res       (res)
    );

    assign o_header_byte  = res.header;
    assign o_address_byte = res.addr;
    assign o_data_byte0   = res.data[0];
    assign o_data_byte1   = res.data[1];
    assign o_data_byte2   = res.data[2];
    assign o_data_byte3   = res.data[3];

endmodule

// ===== tb/tb_sign_bit_packet_deframer.sv =====
// self-checking testbench for the sign-bit packet deframer
module tb_sign_bit_packet_deframer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IdleLimit   = 1000;
    localparam int PktBytes    = 1200;
    localparam int DrainCycles = 16;
    localparam int MaxReports  = 10;

    localparam sbpd_pkg::t_res ResZero = '0;
    localparam sbpd_pkg::t_res ResOnes = '1;

    typedef enum logic [1:0] {EXP_MODEL, EXP_NONE, EXP_ONE} t_exp;

    typedef struct packed {
        logic [sbpd_pkg::ByteW-1:0] rx;
        t_exp                       kind;
        sbpd_pkg::t_res             res;
    } t_step;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_rx_byte;
    logic       o_valid;
    logic       i_stall;
    logic [7:0] o_header_byte;
    logic [7:0] o_address_byte;
    logic [7:0] o_data_byte0;
    logic [7:0] o_data_byte1;
    logic [7:0] o_data_byte2;
    logic [7:0] o_data_byte3;

    sign_bit_packet_deframer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_rx_byte     (i_rx_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_header_byte (o_header_byte),
        .o_address_byte(o_address_byte),
        .o_data_byte0  (o_data_byte0),
        .o_data_byte1  (o_data_byte1),
        .o_data_byte2  (o_data_byte2),
        .o_data_byte3  (o_data_byte3)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // deframer state mirrored by the predictor
    sbpd_pkg::t_pos             rx_pos;
    logic [sbpd_pkg::ByteW-1:0] hdr_q;
    logic [sbpd_pkg::SignW-1:0] sign_q;
    logic [sbpd_pkg::ByteW-1:0] addr_q;
    logic [sbpd_pkg::ByteW-1:0] data_q [sbpd_pkg::NumData];

    sbpd_pkg::t_res pending_pkts[$];
    int   mismatches;
    int   pkt_sent;
    bit   tx_quiet;
    bit   rx_quiet;

    // directed beats: noise, all-zero packet, all-ones packet, restart then bad checksum
    t_step steps [27] = '{
        '{8'h7F, EXP_NONE,  ResZero},
        '{8'h80, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_ONE,   ResZero},
        '{8'hFF, EXP_MODEL, ResZero},
        '{8'h7F, EXP_MODEL, ResZero},
        '{8'h7F, EXP_MODEL, ResZero},
        '{8'h7F, EXP_MODEL, ResZero},
        '{8'h7F, EXP_MODEL, ResZero},
        '{8'h7F, EXP_MODEL, ResZero},
        '{8'h7F, EXP_MODEL, ResZero},
        '{8'h7A, EXP_ONE,   ResOnes},
        '{8'h81, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h80, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h00, EXP_MODEL, ResZero},
        '{8'h01, EXP_NONE,  ResZero}
    };

    task automatic deframe_byte(input logic [sbpd_pkg::ByteW-1:0] rx, output bit got,
                                output sbpd_pkg::t_res pkt);
        logic [sbpd_pkg::ByteW-1:0] chk;
        logic [sbpd_pkg::ByteW-1:0] sum;
        int                         k;

        got = 1'b0;
        pkt = '0;
        if (rx[sbpd_pkg::SyncBit]) begin
            hdr_q  = rx;
            rx_pos = sbpd_pkg::POS_SIGN;
        end else begin
            case (rx_pos)
                sbpd_pkg::POS_HUNT: ;
                sbpd_pkg::POS_SIGN: begin
                    sign_q = rx[sbpd_pkg::SignW-1:0];
                    rx_pos = sbpd_pkg::POS_ADDR;
                end
                sbpd_pkg::POS_ADDR: begin
                    addr_q = rx;
                    rx_pos = sbpd_pkg::POS_D0;
                end
                sbpd_pkg::POS_CHK: begin
                    pkt.header = {sign_q[sbpd_pkg::SignHdr], hdr_q[6:0]};
                    pkt.addr   = {sign_q[sbpd_pkg::SignAddr], addr_q[6:0]};
                    sum = pkt.header + pkt.addr;
                    for (k = 0; k < sbpd_pkg::NumData; k++) begin
                        pkt.data[k] = {sign_q[sbpd_pkg::SignData0-k], data_q[k][6:0]};
                        sum += pkt.data[k];
                    end
                    chk    = {sign_q[sbpd_pkg::SignChk], rx[6:0]};
                    got    = (sum == chk);
                    rx_pos = sbpd_pkg::POS_HUNT;
                end
                default: begin
                    data_q[int'(rx_pos) - int'(sbpd_pkg::POS_D0)] = rx;
                    rx_pos = rx_pos + 3'd1;
                end
            endcase
        end
    endtask

    task automatic send_byte(input logic [sbpd_pkg::ByteW-1:0] rx, input t_exp kind,
                             input sbpd_pkg::t_res res);
        int             gap;
        bit             got;
        sbpd_pkg::t_res pred;

        gap = tx_quiet ? 0 : $urandom_range(0, 8);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        do @(posedge i_clk); while (o_stall);
        deframe_byte(rx, got, pred);
        if (kind == EXP_ONE) begin
            pending_pkts.push_back(res);
        end else if (kind == EXP_MODEL && got) begin
            pending_pkts.push_back(pred);
        end
    endtask

    // builds a packet from random restored bytes; cut < 8 truncates it
    task automatic send_packet(input int cut, input bit bad);
        logic [sbpd_pkg::ByteW-1:0] v [6];
        logic [sbpd_pkg::ByteW-1:0] chk;
        logic [sbpd_pkg::SignW-1:0] sign;
        logic [sbpd_pkg::ByteW-1:0] beats [8];
        int                         k;

        chk = '0;
        for (k = 0; k < 6; k++) begin
            v[k] = 8'($urandom);
            chk += v[k];
        end
        sign = {v[0][7], v[1][7], v[2][7], v[3][7], v[4][7], v[5][7], chk[7]};
        if (bad) begin
            if ($urandom_range(0, 1) == 0) begin
                chk[6:0] = chk[6:0] ^ 7'($urandom_range(1, 127));
            end else begin
                sign[sbpd_pkg::SignChk] = ~sign[sbpd_pkg::SignChk];
            end
        end
        beats[0] = {1'b1, v[0][6:0]};
        beats[1] = {1'b0, sign};
        beats[2] = {1'b0, v[1][6:0]};
        for (k = 0; k < sbpd_pkg::NumData; k++) begin
            beats[3+k] = {1'b0, v[2+k][6:0]};
        end
        beats[7] = {1'b0, chk[6:0]};
        for (k = 0; k < cut; k++) begin
            send_byte(beats[k], EXP_MODEL, '0);
        end
        pkt_sent += cut;
    endtask

    task automatic check_result(input sbpd_pkg::t_res got);
        sbpd_pkg::t_res             want;
        logic [sbpd_pkg::ByteW-1:0] w [6];
        logic [sbpd_pkg::ByteW-1:0] a [6];
        string                      names [6];
        int                         k;

        names = '{"header", "address", "data0", "data1", "data2", "data3"};
        if (pending_pkts.size() == 0) begin
            mismatches++;
            if (mismatches <= MaxReports) begin
                $display("unexpected packet: header %h address %h data %h",
                         got.header, got.addr, got.data);
            end
        end else begin
            want = pending_pkts.pop_front();
            w = '{want.header, want.addr, want.data[0], want.data[1], want.data[2],
                  want.data[3]};
            a = '{got.header, got.addr, got.data[0], got.data[1], got.data[2],
                  got.data[3]};
            for (k = 0; k < 6; k++) begin
                if (w[k] !== a[k]) begin
                    mismatches++;
                    if (mismatches <= MaxReports) begin
                        $display("%s byte: expected %h, got %h", names[k], w[k], a[k]);
                    end
                end
            end
        end
    endtask

    // receiving side
    initial begin
        int             gap;
        int             n_res;
        sbpd_pkg::t_res got;

        i_stall = 1'b0;
        n_res   = 0;
        wait (i_rst_n);
        forever begin
            if (n_res % 8 == 0) begin
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            gap = rx_quiet ? 0 : $urandom_range(0, 8);
            @(negedge i_clk);
            if (gap > 0) begin
                i_stall <= 1'b1;
                repeat (gap) @(negedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!(o_valid && !i_stall));
            got.header  = o_header_byte;
            got.addr    = o_address_byte;
            got.data[0] = o_data_byte0;
            got.data[1] = o_data_byte1;
            got.data[2] = o_data_byte2;
            got.data[3] = o_data_byte3;
            check_result(got);
            n_res++;
        end
    end

    // watchdog on cycles without any beat
    initial begin
        int idle;

        idle = 0;
        wait (i_rst_n);
        while (idle < IdleLimit) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle = 0;
            end else begin
                idle++;
            end
        end
        $display("sign_bit_packet_deframer: mismatch");
        $finish;
    end

    initial begin
        bit paused;

        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_rx_byte  = '0;
        mismatches = 0;
        pkt_sent   = 0;
        tx_quiet   = 1'b0;
        paused     = 1'b0;
        rx_pos     = sbpd_pkg::POS_HUNT;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (steps[i]) begin
            send_byte(steps[i].rx, steps[i].kind, steps[i].res);
        end

        while (pkt_sent < PktBytes) begin
            if ($urandom_range(0, 15) == 0) begin
                tx_quiet = ~tx_quiet;
            end
            // hold off once until the output side has drained
            if (!paused && pkt_sent >= PktBytes / 2) begin
                paused = 1'b1;
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (pending_pkts.size() != 0) @(posedge i_clk);
            end
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 3)) send_byte(8'($urandom), EXP_MODEL, '0);
                1: send_packet($urandom_range(1, 7), 1'b0);
                2: send_packet(8, 1'b1);
                default: send_packet(8, 1'b0);
            endcase
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_pkts.size() != 0) @(posedge i_clk);
        repeat (DrainCycles) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("sign_bit_packet_deframer: match");
        end else begin
            $display("sign_bit_packet_deframer: mismatch");
        end
        $finish;
    end

endmodule
